### design/ehp_pkg.sv
// shared types and constants for the ethernet ipv4 l4 header parser
package ehp_pkg;

	localparam logic [15:0] MaxFrameBytes = 16'hFFFF;
	localparam logic [15:0] DefaultMss    = 16'd1460;
	localparam logic [15:0] EthertypeVlan = 16'h8100;
	localparam logic [15:0] EthertypeArp  = 16'h0806;
	localparam logic [15:0] EthertypeIp   = 16'h0800;
	localparam logic [15:0] EthertypeIpv6 = 16'h86DD;
	localparam logic [7:0]  IpprotoIcmp   = 8'd1;
	localparam logic [7:0]  IpprotoTcp    = 8'd6;
	localparam logic [7:0]  IpprotoUdp    = 8'd17;

	localparam logic [3:0] StEth     = 4'd0;
	localparam logic [3:0] StVlan    = 4'd1;
	localparam logic [3:0] StArp     = 4'd2;
	localparam logic [3:0] StIp6     = 4'd3;
	localparam logic [3:0] StIp4     = 4'd4;
	localparam logic [3:0] StUdp     = 4'd5;
	localparam logic [3:0] StTcp     = 4'd6;
	localparam logic [3:0] StOpts    = 4'd7;
	localparam logic [3:0] StUnknown = 4'd8;
	localparam logic [3:0] StIcmp    = 4'd9;
	localparam logic [3:0] StArpOk   = 4'd10;
	localparam logic [3:0] StIp6Ok   = 4'd11;
	localparam logic [3:0] StUdpOk   = 4'd12;
	localparam logic [3:0] StTcpOk   = 4'd13;

	localparam logic [2:0] ClsTrunc   = 3'd0;
	localparam logic [2:0] ClsArp     = 3'd1;
	localparam logic [2:0] ClsIpv6    = 3'd2;
	localparam logic [2:0] ClsUnknown = 3'd3;
	localparam logic [2:0] ClsIcmp    = 3'd4;
	localparam logic [2:0] ClsUdp     = 3'd5;
	localparam logic [2:0] ClsTcp     = 3'd6;

	localparam logic [7:0] OptEnd  = 8'd0;
	localparam logic [7:0] OptNop  = 8'd1;
	localparam logic [7:0] OptMss  = 8'd2;
	localparam logic [7:0] OptWs   = 8'd3;
	localparam logic [7:0] OptSack = 8'd4;

	localparam int QueueDepth = 4;
	localparam int QueueAw    = 2;

	typedef struct packed {
		logic [2:0]  app_class;
		logic [15:0] vlan_tag;
		logic [63:0] ip_pair;
		logic [31:0] port_pair;
		logic [7:0]  tcp_flag_bits;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [15:0] window_raw;
		logic [15:0] max_segment;
		logic [7:0]  window_shift;
		logic        sack_permitted;
		logic [16:0] payload_length;
	} result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

endpackage

### design/ehp_front.sv
// input byte queue feeding the parse engine
module ehp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ehp_pkg::item_t  in_item,
	output logic            q_valid,
	input  logic            q_ready,
	output ehp_pkg::item_t  q_item
);

	ehp_pkg::item_t mem_q [ehp_pkg::QueueDepth];
	logic [ehp_pkg::QueueAw-1:0] wr_q;
	logic [ehp_pkg::QueueAw-1:0] rd_q;
	logic [ehp_pkg::QueueAw:0]   cnt_q;
	logic push;
	logic pop;

	assign in_ready = (cnt_q != ehp_pkg::QueueAw'(0) + (ehp_pkg::QueueAw+1)'(ehp_pkg::QueueDepth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (ehp_pkg::QueueAw+1)'(push) - (ehp_pkg::QueueAw+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ehp_pkg::QueueAw+1)'(ehp_pkg::QueueDepth))
		else $error("queue overflow");
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("count did not follow push");
	a_count_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("count did not follow pop");

endmodule

### design/ehp_engine.sv
// header walker: consumes one byte per cycle and emits a result on the last byte; that byte waits on a full result
module ehp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  ehp_pkg::item_t    q_item,
	output logic              res_valid,
	input  logic              res_ready,
	output ehp_pkg::result_t  res
);

	logic [15:0] pos_q;
	logic [15:0] hstart_q;
	logic [3:0]  stage_q;
	logic [15:0] proto_q;
	logic [5:0]  iphl_q;
	logic [5:0]  tcphl_q;
	logic [7:0]  otype_q;
	logic [7:0]  oleft_q;
	logic [7:0]  oidx_q;
	logic [15:0] vlan_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [31:0] ports_q;
	logic [7:0]  flags_q;
	logic [31:0] seq_q;
	logic [31:0] ack_q;
	logic [15:0] win_q;
	logic [15:0] mss_q;
	logic [7:0]  ws_q;
	logic        sack_q;
	logic [16:0] pay_q;

	logic [3:0]  stage_d;
	logic [15:0] hstart_d;
	logic [15:0] proto_d;
	logic [5:0]  iphl_d;
	logic [5:0]  tcphl_d;
	logic [7:0]  otype_d;
	logic [7:0]  oleft_d;
	logic [7:0]  oidx_d;
	logic [15:0] vlan_d;
	logic [31:0] src_d;
	logic [31:0] dst_d;
	logic [31:0] ports_d;
	logic [7:0]  flags_d;
	logic [31:0] seq_d;
	logic [31:0] ack_d;
	logic [15:0] win_d;
	logic [15:0] mss_d;
	logic [7:0]  ws_d;
	logic        sack_d;
	logic [16:0] pay_d;

	logic [15:0] off;
	logic [7:0]  b;
	logic        take;
	logic        active;
	logic [2:0]  cls;
	logic        out_full_q;
	ehp_pkg::result_t out_q;
	ehp_pkg::result_t res_d;

	// only the last byte of a frame needs the result register to be free
	assign q_ready = !out_full_q || res_ready || !q_item.last_byte;
	assign take    = q_valid && q_ready;
	assign b       = q_item.data_byte;
	assign off     = pos_q - hstart_q;
	assign active  = (pos_q != ehp_pkg::MaxFrameBytes);

	function automatic logic [5:0] hlen(input logic [3:0] n);
		logic [5:0] v;
		v = {n, 2'b00};
		return (v < 6'd20) ? 6'd20 : v;
	endfunction

	always_comb begin
		stage_d = stage_q; hstart_d = hstart_q; proto_d = proto_q;
		iphl_d = iphl_q; tcphl_d = tcphl_q; otype_d = otype_q;
		oleft_d = oleft_q; oidx_d = oidx_q; vlan_d = vlan_q;
		src_d = src_q; dst_d = dst_q; ports_d = ports_q; flags_d = flags_q;
		seq_d = seq_q; ack_d = ack_q; win_d = win_q; mss_d = mss_q;
		ws_d = ws_q; sack_d = sack_q; pay_d = pay_q;
		if (active) begin
			unique case (stage_q)
				ehp_pkg::StEth, ehp_pkg::StVlan: begin
					if (stage_q == ehp_pkg::StVlan && off < 16'd2) vlan_d = {vlan_q[7:0], b};
					if ((stage_q == ehp_pkg::StEth && off == 16'd12) ||
					    (stage_q == ehp_pkg::StVlan && off == 16'd2)) proto_d = {b, 8'h00};
					if ((stage_q == ehp_pkg::StEth && off == 16'd13) ||
					    (stage_q == ehp_pkg::StVlan && off == 16'd3)) begin
						proto_d = {proto_q[15:8], b};
						hstart_d = pos_q + 16'd1;
						if (stage_q == ehp_pkg::StEth && proto_d == ehp_pkg::EthertypeVlan)
							stage_d = ehp_pkg::StVlan;
						else if (proto_d == ehp_pkg::EthertypeArp) stage_d = ehp_pkg::StArp;
						else if (proto_d == ehp_pkg::EthertypeIp) stage_d = ehp_pkg::StIp4;
						else if (proto_d == ehp_pkg::EthertypeIpv6) stage_d = ehp_pkg::StIp6;
						else begin
							stage_d = ehp_pkg::StUnknown;
							hstart_d = hstart_q;
						end
					end
				end
				ehp_pkg::StArp: begin
					if (off >= 16'd14 && off <= 16'd17) src_d = {src_q[23:0], b};
					if (off >= 16'd24 && off <= 16'd27) dst_d = {dst_q[23:0], b};
					if (off == 16'd27) stage_d = ehp_pkg::StArpOk;
				end
				ehp_pkg::StIp6: begin
					if (off == 16'd39) stage_d = ehp_pkg::StIp6Ok;
				end
				ehp_pkg::StIp4: begin
					if (off == 16'd0) iphl_d = hlen(b[3:0]);
					if (off == 16'd2 || off == 16'd3) pay_d = {pay_q[8:0], b};
					if (off == 16'd9) proto_d = {8'h00, b};
					if (off >= 16'd12 && off <= 16'd15) src_d = {src_q[23:0], b};
					if (off >= 16'd16 && off <= 16'd19) dst_d = {dst_q[23:0], b};
					if (off + 16'd1 == {10'd0, iphl_d}) begin
						pay_d = pay_d - {11'd0, iphl_d};
						hstart_d = pos_q + 16'd1;
						if (proto_d[7:0] == ehp_pkg::IpprotoIcmp && proto_d[15:8] == 8'd0)
							stage_d = ehp_pkg::StIcmp;
						else if (proto_d == {8'd0, ehp_pkg::IpprotoUdp}) stage_d = ehp_pkg::StUdp;
						else if (proto_d == {8'd0, ehp_pkg::IpprotoTcp}) stage_d = ehp_pkg::StTcp;
						else stage_d = ehp_pkg::StUnknown;
						if (stage_d == ehp_pkg::StIcmp || stage_d == ehp_pkg::StUnknown)
							hstart_d = hstart_q;
					end
				end
				ehp_pkg::StUdp: begin
					if (off < 16'd4) ports_d = {ports_q[23:0], b};
					if (off == 16'd7) stage_d = ehp_pkg::StUdpOk;
				end
				ehp_pkg::StTcp: begin
					if (off < 16'd4) ports_d = {ports_q[23:0], b};
					else if (off < 16'd8) seq_d = {seq_q[23:0], b};
					else if (off < 16'd12) ack_d = {ack_q[23:0], b};
					else if (off == 16'd12) tcphl_d = hlen(b[7:4]);
					else if (off == 16'd13) flags_d = b;
					else if (off < 16'd16) win_d = {win_q[7:0], b};
					if (off == 16'd19) begin
						pay_d = pay_q - {11'd0, tcphl_q};
						oidx_d = '0;
						stage_d = (tcphl_q > 6'd20) ? ehp_pkg::StOpts : ehp_pkg::StTcpOk;
					end
				end
				ehp_pkg::StOpts: begin
					if (oidx_q == 8'd0) begin
						otype_d = b;
						if (b == ehp_pkg::OptEnd) stage_d = ehp_pkg::StTcpOk;
						else if (b != ehp_pkg::OptNop) oidx_d = 8'd1;
					end else if (oidx_q == 8'd1) begin
						if (b < 8'd2) stage_d = ehp_pkg::StTcpOk;
						else begin
							oleft_d = b - 8'd2;
							if (otype_q == ehp_pkg::OptSack) sack_d = 1'b1;
							oidx_d = (oleft_d == 8'd0) ? 8'd0 : 8'd2;
						end
					end else begin
						if (otype_q == ehp_pkg::OptMss && oidx_q == 8'd2) proto_d = {8'd0, b};
						if (otype_q == ehp_pkg::OptMss && oidx_q == 8'd3) mss_d = {proto_q[7:0], b};
						if (otype_q == ehp_pkg::OptWs && oidx_q == 8'd2) ws_d = b;
						if (oidx_q < 8'd4) oidx_d = oidx_q + 8'd1;
						oleft_d = oleft_q - 8'd1;
						if (oleft_d == 8'd0) oidx_d = 8'd0;
					end
					if (stage_d == ehp_pkg::StOpts && off + 16'd1 >= {10'd0, tcphl_q})
						stage_d = ehp_pkg::StTcpOk;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (stage_d)
			ehp_pkg::StArpOk:   cls = ehp_pkg::ClsArp;
			ehp_pkg::StIp6Ok:   cls = ehp_pkg::ClsIpv6;
			ehp_pkg::StUnknown: cls = ehp_pkg::ClsUnknown;
			ehp_pkg::StIcmp:    cls = ehp_pkg::ClsIcmp;
			ehp_pkg::StUdpOk:   cls = ehp_pkg::ClsUdp;
			ehp_pkg::StOpts, ehp_pkg::StTcpOk: cls = ehp_pkg::ClsTcp;
			default:            cls = ehp_pkg::ClsTrunc;
		endcase
	end

	always_comb begin
		res_d = '0;
		res_d.app_class = cls;
		if (cls != ehp_pkg::ClsTrunc) begin
			res_d.vlan_tag       = vlan_d;
			res_d.ip_pair        = {src_d, dst_d};
			res_d.port_pair      = ports_d;
			res_d.tcp_flag_bits  = flags_d;
			res_d.seq_number     = seq_d;
			res_d.ack_number     = ack_d;
			res_d.window_raw     = win_d;
			res_d.max_segment    = (cls == ehp_pkg::ClsTcp) ? mss_d : 16'd0;
			res_d.window_shift   = ws_d;
			res_d.sack_permitted = sack_d;
			res_d.payload_length = pay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hstart_q <= '0; stage_q <= ehp_pkg::StEth; proto_q <= '0;
			iphl_q <= '0; tcphl_q <= '0; otype_q <= '0; oleft_q <= '0; oidx_q <= '0;
			vlan_q <= '0; src_q <= '0; dst_q <= '0; ports_q <= '0; flags_q <= '0;
			seq_q <= '0; ack_q <= '0; win_q <= '0; mss_q <= ehp_pkg::DefaultMss;
			ws_q <= '0; sack_q <= 1'b0; pay_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (res_ready) out_full_q <= 1'b0;
			if (take) begin
				if (q_item.last_byte) begin
					out_full_q <= 1'b1;
					pos_q <= '0; hstart_q <= '0; stage_q <= ehp_pkg::StEth; proto_q <= '0;
					iphl_q <= '0; tcphl_q <= '0; otype_q <= '0; oleft_q <= '0;
					oidx_q <= '0; vlan_q <= '0; src_q <= '0; dst_q <= '0; ports_q <= '0;
					flags_q <= '0; seq_q <= '0; ack_q <= '0; win_q <= '0;
					mss_q <= ehp_pkg::DefaultMss; ws_q <= '0; sack_q <= 1'b0; pay_q <= '0;
				end else begin
					if (active) pos_q <= pos_q + 16'd1;
					hstart_q <= hstart_d; stage_q <= stage_d; proto_q <= proto_d;
					iphl_q <= iphl_d; tcphl_q <= tcphl_d; otype_q <= otype_d;
					oleft_q <= oleft_d; oidx_q <= oidx_d; vlan_q <= vlan_d; src_q <= src_d;
					dst_q <= dst_d; ports_q <= ports_d; flags_q <= flags_d; seq_q <= seq_d;
					ack_q <= ack_d; win_q <= win_d; mss_q <= mss_d; ws_q <= ws_d;
					sack_q <= sack_d; pay_q <= pay_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_item.last_byte) begin
			out_q <= res_d;
		end
	end

	assign res_valid = out_full_q;
	assign res       = out_q;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_item.last_byte) |=> (pos_q == 16'd0 && stage_q == ehp_pkg::StEth))
		else $error("parser did not restart after frame");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result dropped");
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && !res_ready) |-> !(take && q_item.last_byte))
		else $error("last byte taken while result blocked");

endmodule

### design/ethernet_ipv4_l4_header_parser_top.sv
// top level of the ethernet ipv4 l4 header parser
// the last byte passes through the byte queue and then the parse stage, which registers the result
// throughput: one byte per cycle unless a last byte waits on a full result; a result register lets the next frame start
// the byte queue holds four transactions so each side may stall on its own
// reset: asynchronous, clears the queue pointers, the parse state and the result valid flag
module ethernet_ipv4_l4_header_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// app_class[2:0] vlan_tag[18:3] ip_pair[82:19] port_pair[114:83]
	// tcp_flag_bits[122:115] seq_number[154:123] ack_number[186:155]
	// window_raw[202:187] max_segment[218:203] window_shift[226:219]
	// sack_permitted[227] payload_length[244:228] zeros[247:245]
	output logic [247:0] m_axis_tdata
);

	ehp_pkg::item_t   in_item;
	ehp_pkg::item_t   q_item;
	ehp_pkg::result_t res;
	logic q_valid;
	logic q_ready;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	ehp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	ehp_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {3'b000, res.payload_length, res.sack_permitted, res.window_shift,
		res.max_segment, res.window_raw, res.ack_number, res.seq_number, res.tcp_flag_bits,
		res.port_pair, res.ip_pair, res.vlan_tag, res.app_class};

endmodule
